/* rtl/wss_pkg.sv */
package wss_pkg;

    // Defaults for the top-level parameters
    localparam int SECTION_BYTES_DEF   = 6;
    localparam int WINDOW_SECTIONS_DEF = 32;

    localparam logic [15:0] TIMEOUT_RESET = 16'd30;

    // Input op codes
    localparam logic [1:0] OP_GET   = 2'd0;
    localparam logic [1:0] OP_FLOW  = 2'd1;
    localparam logic [1:0] OP_TICK  = 2'd2;

    // Flow-control codes
    localparam logic [2:0] FL_SEND   = 3'd0;
    localparam logic [2:0] FL_WAIT   = 3'd1;
    localparam logic [2:0] FL_RESEND = 3'd2;
    localparam logic [2:0] FL_DONE   = 3'd3;
    localparam logic [2:0] FL_ABORT  = 3'd4;

    // Result kinds
    localparam logic [2:0] K_OK    = 3'd0;
    localparam logic [2:0] K_REJ   = 3'd1;
    localparam logic [2:0] K_DATA  = 3'd2;
    localparam logic [2:0] K_ALARM = 3'd3;
    localparam logic [2:0] K_UNSUP = 3'd4;

    // Alarm ids
    localparam logic ALARM_TIMEOUT = 1'b0;
    localparam logic ALARM_FLOW    = 1'b1;

    localparam int IN_DATA_W  = 32;
    localparam int OUT_DATA_W = 56;

    // One step of the section unit
    typedef struct packed {
        logic        final_sec;  // this section reaches the end of data
        logic [15:0] step;       // bytes in this section
        logic [15:0] next_sent;  // sent_bytes after this section
    } sec_res_t;

endpackage

/* rtl/wss_section_unit.sv */
module wss_section_unit
    import wss_pkg::*;
#(
    parameter int SECTION_BYTES = SECTION_BYTES_DEF
) (
    input  logic [15:0] sent,
    input  logic [15:0] total,
    output sec_res_t    res
);

    logic [16:0] sum;
    logic        more;

    assign sum  = {1'b0, sent} + 17'(SECTION_BYTES);
    assign more = sum < {1'b0, total};

    always_comb begin
        res.final_sec = !more;
        if (more) begin
            res.step      = 16'(SECTION_BYTES);
            res.next_sent = sum[15:0];
        end else begin
            // short tail, wraps if a resend rewound below zero
            res.step      = total - sent;
            res.next_sent = total;
        end
    end

endmodule

/* rtl/windowed_section_sender_core.sv */
// Windowed section sender.
// Input channel s_*: one item per handshake, op in s_tuser, fields in s_tdata.
// Result channel m_*: one result per handshake, kind in m_tuser, m_tlast marks
// the final result caused by an input item. cfg_*: writes timeout_ticks,
// always ready; write only while the block is idle.
// Timing: an accepted item is decoded in its accept cycle. A single result
// (ok, reject, unsupported, alarm) passes through the head state into the
// output register; a window of data sections follows at one section per cycle
// while the receiver takes them, from the section unit, up to WINDOW_SECTIONS
// sections. No further item is accepted until the window has been sent.
// Items without a result leave the sequencer idle.
// s_tready is high only while the sequencer is idle.
// A registered output stage holds the current result; when the receiver
// stalls the sequencer waits and nothing is dropped.
// Reset (aresetn low, synchronous): idle, not busy, sent, total and window
// counts cleared, timeout_ticks and the tick counter set to 30, no result pending.
module windowed_section_sender_core
    import wss_pkg::*;
#(
    parameter int SECTION_BYTES   = SECTION_BYTES_DEF,
    parameter int WINDOW_SECTIONS = WINDOW_SECTIONS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // net_id[7:0], attr[9:8], total_size[25:10], flow_code[28:26], zero pad
    input  logic [IN_DATA_W-1:0]  s_tdata,
    // op[1:0]
    input  logic [1:0]            s_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // out_net[7:0], section_index[12:8], byte_offset[28:13], byte_count[31:29],
    // alarm_id[32], response_size[48:33], zero pad
    output logic [OUT_DATA_W-1:0] m_tdata,
    // kind[2:0]
    output logic [2:0]            m_tuser,
    output logic                  m_tlast,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [15:0]           cfg_data
);

    localparam int IDX_W = (WINDOW_SECTIONS > 1) ? $clog2(WINDOW_SECTIONS) : 1;
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(WINDOW_SECTIONS - 1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_HEAD = 2'd1;
    localparam logic [1:0] ST_WIN  = 2'd2;

    logic [1:0]  state_reg, state_next;
    logic [1:0]  busy_reg, busy_next;
    logic [15:0] sent_reg, sent_next;
    logic [15:0] total_reg, total_next;
    logic [7:0]  win_reg, win_next;
    logic [15:0] ticks_reg, ticks_next;
    logic [7:0]  reply_net_reg, reply_net_next;
    logic [15:0] timeout_reg;

    logic [2:0]  hd_kind_reg, hd_kind_next;
    logic        hd_alarm_reg, hd_alarm_next;
    logic [15:0] hd_rsize_reg, hd_rsize_next;
    logic [7:0]  net_reg, net_next;
    logic        win_pend_reg, win_pend_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [7:0]  acc_reg, acc_next;

    logic                  m_tvalid_reg, m_tvalid_next;
    logic [OUT_DATA_W-1:0] m_tdata_reg, m_tdata_next;
    logic [2:0]            m_tuser_reg, m_tuser_next;
    logic                  m_tlast_reg, m_tlast_next;

    logic [7:0]  in_net;
    logic [1:0]  in_attr;
    logic [15:0] in_size;
    logic [2:0]  in_flow;
    logic        in_accept;
    logic        out_free;
    logic        at_end;
    logic [IDX_W+4:0] idx_ext;
    sec_res_t    sec;

    assign in_net  = s_tdata[7:0];
    assign in_attr = s_tdata[9:8];
    assign in_size = s_tdata[25:10];
    assign in_flow = s_tdata[28:26];

    assign s_tready  = (state_reg == ST_IDLE);
    assign in_accept = s_tvalid && s_tready;
    assign out_free  = !m_tvalid_reg || m_tready;
    assign at_end    = sent_reg >= total_reg;
    assign idx_ext   = {5'd0, idx_reg};
    assign cfg_ready = 1'b1;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;

    wss_section_unit #(
        .SECTION_BYTES(SECTION_BYTES)
    ) u_sec (
        .sent (sent_reg),
        .total(total_reg),
        .res  (sec)
    );

    always_comb begin
        state_next     = state_reg;
        busy_next      = busy_reg;
        sent_next      = sent_reg;
        total_next     = total_reg;
        win_next       = win_reg;
        ticks_next     = ticks_reg;
        reply_net_next = reply_net_reg;
        hd_kind_next   = hd_kind_reg;
        hd_alarm_next  = hd_alarm_reg;
        hd_rsize_next  = hd_rsize_reg;
        net_next       = net_reg;
        win_pend_next  = win_pend_reg;
        idx_next       = idx_reg;
        acc_next       = acc_reg;
        m_tvalid_next  = m_tvalid_reg && !m_tready;
        m_tdata_next   = m_tdata_reg;
        m_tuser_next   = m_tuser_reg;
        m_tlast_next   = m_tlast_reg;

        case (state_reg)
            ST_IDLE: begin
                if (in_accept) begin
                    logic head;
                    logic win;
                    logic idle;
                    head = 1'b0;
                    win  = 1'b0;
                    idle = 1'b0;
                    hd_alarm_next = 1'b0;
                    hd_rsize_next = 16'd0;
                    net_next      = in_net;
                    case (s_tuser)
                        OP_GET: begin
                            reply_net_next = in_net;
                            head = 1'b1;
                            if (in_attr != 2'd1 && in_attr != 2'd2) begin
                                hd_kind_next = K_UNSUP;
                            end else if (busy_reg != 2'd0) begin
                                hd_kind_next = K_REJ;
                            end else begin
                                hd_kind_next  = K_OK;
                                hd_rsize_next = in_size;
                                busy_next     = in_attr;
                                total_next    = in_size;
                                if (in_attr == 2'd2 && in_size == 16'd0) begin
                                    idle = 1'b1;
                                end else begin
                                    win = 1'b1;
                                end
                            end
                        end
                        OP_FLOW: begin
                            if (in_attr != 2'd0) begin
                                head = 1'b1;
                                hd_kind_next = K_UNSUP;
                            end else if (busy_reg == 2'd0) begin
                                head = 1'b1;
                                hd_kind_next  = K_ALARM;
                                hd_alarm_next = ALARM_FLOW;
                                idle = 1'b1;
                            end else begin
                                case (in_flow)
                                    FL_SEND, FL_WAIT: begin
                                        if (at_end) begin
                                            head = 1'b1;
                                            hd_kind_next  = K_ALARM;
                                            hd_alarm_next = ALARM_FLOW;
                                            idle = 1'b1;
                                        end else if (in_flow == FL_SEND) begin
                                            win = 1'b1;
                                        end else begin
                                            ticks_next = timeout_reg;
                                        end
                                    end
                                    FL_RESEND: begin
                                        sent_next = sent_reg - {8'd0, win_reg};
                                        win = 1'b1;
                                    end
                                    FL_DONE, FL_ABORT: begin
                                        idle = 1'b1;
                                    end
                                    default: begin
                                    end
                                endcase
                            end
                        end
                        OP_TICK: begin
                            if (busy_reg != 2'd0 && ticks_reg != 16'd0) begin
                                ticks_next = ticks_reg - 16'd1;
                                if (ticks_reg == 16'd1) begin
                                    head = 1'b1;
                                    hd_kind_next  = K_ALARM;
                                    hd_alarm_next = ALARM_TIMEOUT;
                                    net_next      = reply_net_reg;
                                    idle = 1'b1;
                                end
                            end
                        end
                        default: begin
                        end
                    endcase
                    if (idle) begin
                        busy_next  = 2'd0;
                        sent_next  = 16'd0;
                        win_next   = 8'd0;
                        total_next = 16'd0;
                        ticks_next = timeout_reg;
                    end
                    win_pend_next = win;
                    idx_next      = '0;
                    acc_next      = 8'd0;
                    if (head) begin
                        state_next = ST_HEAD;
                    end else if (win) begin
                        state_next = ST_WIN;
                    end
                end
            end
            ST_HEAD: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tuser_next  = hd_kind_reg;
                    m_tlast_next  = !win_pend_reg;
                    m_tdata_next  = {7'd0, hd_rsize_reg, hd_alarm_reg, 3'd0, 16'd0,
                                     5'd0, net_reg};
                    state_next    = win_pend_reg ? ST_WIN : ST_IDLE;
                end
            end
            ST_WIN: begin
                if (out_free) begin
                    logic done;
                    done = sec.final_sec || (idx_reg == IDX_LAST);
                    m_tvalid_next = 1'b1;
                    m_tuser_next  = K_DATA;
                    m_tlast_next  = done;
                    m_tdata_next  = {7'd0, 16'd0, 1'b0, sec.step[2:0], sent_reg,
                                     idx_ext[4:0], net_reg};
                    sent_next     = sec.next_sent;
                    acc_next      = acc_reg + sec.step[7:0];
                    idx_next      = idx_reg + IDX_W'(1);
                    if (done) begin
                        win_next   = acc_reg + sec.step[7:0];
                        ticks_next = timeout_reg;
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            busy_reg      <= 2'd0;
            sent_reg      <= 16'd0;
            total_reg     <= 16'd0;
            win_reg       <= 8'd0;
            ticks_reg     <= TIMEOUT_RESET;
            reply_net_reg <= 8'd0;
            timeout_reg   <= TIMEOUT_RESET;
            m_tvalid_reg  <= 1'b0;
        end else begin
            state_reg     <= state_next;
            busy_reg      <= busy_next;
            sent_reg      <= sent_next;
            total_reg     <= total_next;
            win_reg       <= win_next;
            ticks_reg     <= ticks_next;
            reply_net_reg <= reply_net_next;
            m_tvalid_reg  <= m_tvalid_next;
            if (cfg_valid && cfg_ready) begin
                timeout_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        hd_kind_reg  <= hd_kind_next;
        hd_alarm_reg <= hd_alarm_next;
        hd_rsize_reg <= hd_rsize_next;
        net_reg      <= net_next;
        win_pend_reg <= win_pend_next;
        idx_reg      <= idx_next;
        acc_reg      <= acc_next;
        m_tdata_reg  <= m_tdata_next;
        m_tuser_reg  <= m_tuser_next;
        m_tlast_reg  <= m_tlast_next;
    end

endmodule

/* rtl/wss_checker.sv */
module wss_checker
    import wss_pkg::*;
(
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [OUT_DATA_W-1:0] m_tdata,
    input logic [2:0]            m_tuser,
    input logic                  m_tlast
);

    // stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
            && $stable(m_tlast))
        else $error("stalled result changed");

    a_kind: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tuser == K_OK || m_tuser == K_REJ || m_tuser == K_DATA
            || m_tuser == K_ALARM || m_tuser == K_UNSUP))
        else $error("bad result kind");

    // reject, unsupported and alarm always end the item's results
    a_single_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == K_REJ || m_tuser == K_UNSUP || m_tuser == K_ALARM)
            |-> m_tlast)
        else $error("single result without tlast");

    a_nondata_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser != K_DATA |-> m_tdata[31:8] == 24'd0)
        else $error("section fields set on a non-data result");

endmodule

bind windowed_section_sender_core wss_checker u_wss_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser),
    .m_tlast (m_tlast)
);
